// ----- hw/rtl/stt_pkg.sv -----
// shared types and constants for the client steering table
// used by every module of the block; no dependencies
`timescale 1ns / 1ps
package stt_pkg;

	localparam int SLOTS_DEFAULT = 64;

	localparam logic [2:0] MODE_PROBE    = 3'd0;
	localparam logic [2:0] MODE_DISASSOC = 3'd1;
	localparam logic [2:0] MODE_ASSOC    = 3'd2;
	localparam logic [2:0] MODE_AUTH     = 3'd3;
	localparam logic [2:0] MODE_TICK     = 3'd4;

	localparam logic [1:0] BAND_NONE = 2'd0;
	localparam logic [1:0] BAND_5    = 2'd1;
	localparam logic [1:0] BAND_24   = 2'd2;

	localparam logic [1:0] LINK_INIT     = 2'd0;
	localparam logic [1:0] LINK_ASSOC    = 2'd1;
	localparam logic [1:0] LINK_DISASSOC = 2'd2;

	localparam logic CMD_ADD = 1'b0;
	localparam logic CMD_DEL = 1'b1;

	localparam logic signed [7:0] RSSI_NONE = 8'sh80;

	localparam logic signed [7:0] STRONG_RESET = -8'sd65;
	localparam logic signed [7:0] WEAK_RESET   = -8'sd75;
	localparam logic [15:0]       EXPIRY_RESET = 16'd300;

	localparam int ADDR_W = 5;
	localparam logic [2:0] REG_STRONG  = 3'd0;
	localparam logic [2:0] REG_WEAK    = 3'd1;
	localparam logic [2:0] REG_EXPIRY  = 3'd2;
	localparam logic [2:0] REG_24_PRES = 3'd3;
	localparam logic [2:0] REG_5_PRES  = 3'd4;
	localparam logic [2:0] REG_24_RDY  = 3'd5;
	localparam logic [2:0] REG_5_RDY   = 3'd6;

	typedef struct packed {
		logic [2:0]         mode;
		logic [47:0]        mac;
		logic [1:0]         band;
		logic signed [7:0]  rssi_a;
		logic signed [7:0]  rssi_b;
		logic signed [7:0]  rssi_c;
		logic signed [7:0]  rssi_d;
		logic               vht;
		logic [3:0]         streams;
		logic [31:0]        now_seconds;
	} req_t;

	typedef struct packed {
		logic        command;
		logic [1:0]  cmd_band;
		logic [47:0] cmd_mac;
		logic        last;
	} rsp_t;

	// classified event handed from front to back
	typedef struct packed {
		logic [2:0]         mode;
		logic [47:0]        mac;
		logic [1:0]         band;
		logic signed [7:0]  best;
		logic               vht;
		logic [3:0]         streams;
		logic [31:0]        now;
	} work_t;

	typedef struct packed {
		logic [47:0]        mac;
		logic               vht;
		logic [3:0]         streams;
		logic [1:0]         band;
		logic [1:0]         link;
		logic signed [7:0]  best;
		logic [31:0]        seen_at;
	} slot_t;

	typedef struct packed {
		logic signed [7:0] strong_lim;
		logic signed [7:0] weak_lim;
		logic [15:0]       expiry;
		logic              pres_24;
		logic              pres_5;
		logic              rdy_24;
		logic              rdy_5;
	} cfg_t;

	// queue status between front and back
	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

endpackage

// ----- hw/rtl/stt_front.sv -----
// front end: accepts events, folds the four rssi readings, drops unknown modes
// depends on stt_pkg
`timescale 1ns / 1ps
module stt_front
	import stt_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   req_valid,
	output logic   req_stall,
	input  req_t   req,
	input  qstat_t qstat,
	output logic   push,
	output work_t  push_data
);

	logic  valid_s1;
	work_t work_s1;
	logic  take;
	logic  known;
	logic signed [7:0] best;
	logic signed [7:0] rd [4];

	always_comb begin
		rd[0] = req.rssi_a;
		rd[1] = req.rssi_b;
		rd[2] = req.rssi_c;
		rd[3] = req.rssi_d;
		best = RSSI_NONE;
		for (int r = 0; r < 4; r++) begin
			if (rd[r] != RSSI_NONE && rd[r] > best) begin
				best = rd[r];
			end
		end
	end

	assign known     = req.mode <= MODE_TICK;
	assign push      = valid_s1 && !qstat.full;
	assign push_data = work_s1;
	assign req_stall = valid_s1 && qstat.full;
	assign take      = req_valid && !req_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= known;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			work_s1.mode    <= req.mode;
			work_s1.mac     <= req.mac;
			work_s1.band    <= req.band;
			work_s1.best    <= best;
			work_s1.vht     <= req.vht;
			work_s1.streams <= req.streams;
			work_s1.now     <= req.now_seconds;
		end
	end

endmodule

// ----- hw/rtl/stt_queue.sv -----
// two-entry queue of classified events between front and back
// depends on stt_pkg
`timescale 1ns / 1ps
module stt_queue
	import stt_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  work_t  push_data,
	input  logic   pop,
	output work_t  head,
	output qstat_t qstat
);

	work_t      ent_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;

	assign head        = ent_q[rp_q];
	assign qstat.full  = cnt_q == 2'd2;
	assign qstat.empty = cnt_q == 2'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= push_data;
		end
	end

endmodule

// ----- hw/rtl/stt_back.sv -----
// back end: slot memory, lookup / eviction scan, tick sweep and command output
// depends on stt_pkg
`timescale 1ns / 1ps
module stt_back
	import stt_pkg::*;
#(
	parameter int CLIENT_SLOTS = SLOTS_DEFAULT
) (
	input  logic   clk,
	input  logic   arst_n,
	input  cfg_t   cfg,
	input  work_t  head,
	input  qstat_t qstat,
	output logic   pop,
	output logic   rsp_valid,
	input  logic   rsp_stall,
	output rsp_t   rsp
);

	localparam int IDX_W = (CLIENT_SLOTS > 1) ? $clog2(CLIENT_SLOTS) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CLIENT_SLOTS - 1);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_RD    = 5'b00010,
		ST_EV    = 5'b00100,
		ST_APPLY = 5'b01000,
		ST_FLUSH = 5'b10000
	} state_t;

	state_t st_q;
	work_t  cur_q;
	logic [IDX_W-1:0] idx_q;
	logic [CLIENT_SLOTS-1:0] valid_q;

	slot_t mem [CLIENT_SLOTS];
	slot_t rd_data_q;

	// scan results
	logic             hit_q;
	logic [IDX_W-1:0] hit_idx_q;
	slot_t            hit_ent_q;
	logic             free_q;
	logic [IDX_W-1:0] free_idx_q;
	logic             ev1_q;
	logic [IDX_W-1:0] ev1_idx_q;
	logic [31:0]      ev1_time_q;
	logic             ev2_q;
	logic [IDX_W-1:0] ev2_idx_q;
	logic [31:0]      ev2_time_q;

	logic pend_q;
	rsp_t pend_data_q;
	logic out_valid_q;
	rsp_t out_q;

	logic  v;
	logic  is_tick;
	logic  is_ins;
	logic  expire;
	logic  st24;
	logic  st5;
	logic  steer;
	logic  out_free;
	logic  advance;
	logic  wr_en;
	logic [IDX_W-1:0] wr_idx;
	slot_t wr_data;
	logic  out_load;
	rsp_t  out_data;
	logic  emit_add;
	logic [IDX_W-1:0] tgt;
	slot_t base;
	slot_t upd;
	logic [31:0] idle;

	assign v        = valid_q[idx_q];
	assign is_tick  = cur_q.mode == MODE_TICK;
	assign is_ins   = cur_q.mode == MODE_ASSOC || cur_q.mode == MODE_AUTH;
	assign out_free = !out_valid_q || !rsp_stall;
	assign idle     = cur_q.now - rd_data_q.seen_at;

	assign expire = v && rd_data_q.link != LINK_ASSOC && cur_q.now >= rd_data_q.seen_at &&
		idle > {16'd0, cfg.expiry};
	assign st24 = rd_data_q.band == BAND_24 && rd_data_q.vht &&
		rd_data_q.best > cfg.strong_lim && cfg.rdy_24;
	assign st5 = rd_data_q.band == BAND_5 && rd_data_q.best < cfg.weak_lim &&
		rd_data_q.best != 8'sd0 && cfg.rdy_5;
	assign steer = v && rd_data_q.link == LINK_ASSOC && (st24 || st5);

	// target slot and new contents for insert or update
	always_comb begin
		if (hit_q) begin
			tgt = hit_idx_q;
		end else if (free_q) begin
			tgt = free_idx_q;
		end else if (ev1_q) begin
			tgt = ev1_idx_q;
		end else begin
			tgt = ev2_idx_q;
		end
		if (hit_q) begin
			base = hit_ent_q;
		end else begin
			base = '0;
			base.mac = cur_q.mac;
		end
		upd = base;
		case (cur_q.mode)
			MODE_PROBE: begin
				upd.best = cur_q.best;
				upd.seen_at = cur_q.now;
				upd.vht = base.vht | cur_q.vht;
			end
			MODE_DISASSOC: begin
				upd.link = LINK_DISASSOC;
				upd.band = BAND_NONE;
			end
			MODE_ASSOC: begin
				upd.seen_at = cur_q.now;
				upd.vht = base.vht | cur_q.vht;
				upd.streams = (cur_q.streams > base.streams) ? cur_q.streams : base.streams;
				upd.band = cur_q.band;
				upd.link = LINK_ASSOC;
			end
			MODE_AUTH: begin
				upd.best = cur_q.best;
				upd.seen_at = cur_q.now;
			end
			default: begin
				upd = base;
			end
		endcase
		emit_add = cur_q.mode == MODE_ASSOC &&
			((cur_q.band == BAND_5 && cfg.pres_5) || (cur_q.band == BAND_24 && cfg.pres_24));
	end

	always_comb begin
		advance  = 1'b1;
		wr_en    = 1'b0;
		wr_idx   = idx_q;
		wr_data  = rd_data_q;
		out_load = 1'b0;
		out_data = pend_data_q;
		pop      = 1'b0;
		case (st_q)
			ST_IDLE: begin
				pop = !qstat.empty;
			end
			ST_EV: begin
				if (is_tick && steer) begin
					advance = !pend_q || out_free;
					wr_en = advance;
					wr_data.link = LINK_INIT;
					wr_data.band = BAND_NONE;
					out_load = advance && pend_q;
					out_data.last = 1'b0;
				end
			end
			ST_APPLY: begin
				advance = !emit_add || out_free;
				wr_en = advance && (is_ins || hit_q);
				wr_idx = tgt;
				wr_data = upd;
				out_load = advance && emit_add;
				out_data.command = CMD_ADD;
				out_data.cmd_band = cur_q.band;
				out_data.cmd_mac = cur_q.mac;
				out_data.last = 1'b1;
			end
			ST_FLUSH: begin
				advance = !pend_q || out_free;
				out_load = pend_q && out_free;
				out_data.last = 1'b1;
			end
			default: begin
				advance = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx] <= wr_data;
		end
		if (st_q == ST_RD) begin
			rd_data_q <= mem[idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			valid_q     <= '0;
			idx_q       <= '0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
			hit_q       <= 1'b0;
			free_q      <= 1'b0;
			ev1_q       <= 1'b0;
			ev2_q       <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
			case (st_q)
				ST_IDLE: begin
					if (pop) begin
						idx_q  <= '0;
						hit_q  <= 1'b0;
						free_q <= 1'b0;
						ev1_q  <= 1'b0;
						ev2_q  <= 1'b0;
						st_q   <= ST_RD;
					end
				end
				ST_RD: begin
					st_q <= ST_EV;
				end
				ST_EV: begin
					if (advance) begin
						if (is_tick) begin
							if (expire) begin
								valid_q[idx_q] <= 1'b0;
							end
							if (steer) begin
								pend_q <= 1'b1;
							end
						end else begin
							if (v && !hit_q && rd_data_q.mac == cur_q.mac) begin
								hit_q <= 1'b1;
							end
							if (!v && !free_q) begin
								free_q <= 1'b1;
							end
							if (v && rd_data_q.link != LINK_ASSOC &&
								rd_data_q.seen_at < ev1_time_q) begin
								ev1_q <= 1'b1;
							end
							if (v && (!ev2_q || rd_data_q.seen_at < ev2_time_q)) begin
								ev2_q <= 1'b1;
							end
						end
						if (idx_q == LAST_IDX) begin
							st_q <= is_tick ? ST_FLUSH : ST_APPLY;
						end else begin
							idx_q <= idx_q + 1'b1;
							st_q  <= ST_RD;
						end
					end
				end
				ST_APPLY: begin
					if (advance) begin
						if (is_ins) begin
							valid_q[tgt] <= 1'b1;
						end
						st_q <= ST_IDLE;
					end
				end
				ST_FLUSH: begin
					if (advance) begin
						pend_q <= 1'b0;
						st_q   <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= out_data;
		end
		if (pop) begin
			cur_q      <= head;
			ev1_time_q <= head.now;
		end
		if (st_q == ST_EV && advance) begin
			if (is_tick) begin
				if (steer) begin
					pend_data_q.command  <= CMD_DEL;
					pend_data_q.cmd_band <= st24 ? BAND_24 : BAND_5;
					pend_data_q.cmd_mac  <= rd_data_q.mac;
					pend_data_q.last     <= 1'b0;
				end
			end else begin
				if (v && !hit_q && rd_data_q.mac == cur_q.mac) begin
					hit_idx_q <= idx_q;
					hit_ent_q <= rd_data_q;
				end
				if (!v && !free_q) begin
					free_idx_q <= idx_q;
				end
				if (v && rd_data_q.link != LINK_ASSOC && rd_data_q.seen_at < ev1_time_q) begin
					ev1_idx_q  <= idx_q;
					ev1_time_q <= rd_data_q.seen_at;
				end
				if (v && (!ev2_q || rd_data_q.seen_at < ev2_time_q)) begin
					ev2_idx_q  <= idx_q;
					ev2_time_q <= rd_data_q.seen_at;
				end
			end
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

endmodule

// ----- hw/rtl/wifi_client_steering_table.sv -----
// top level of the client steering table: config registers, front, queue, back
// depends on stt_pkg, stt_front, stt_queue, stt_back
//
// Usage: events enter on req (req_valid / req_stall), commands leave on rsp
// (rsp_valid / rsp_stall); an item moves on a clock edge with valid high and
// stall low. Limits and interface flags sit on the APB port, one register per
// word; the user must write them only while the block is idle, and the block
// itself does not enforce it. Every event with a known mode walks all
// CLIENT_SLOTS slots of the slot memory one at a time through its single read
// port, reading then evaluating each slot, after a pop and before an apply
// (a flush for a tick); the back takes no new event until that walk ends.
// Probe, disassoc and auth give no command; assoc gives at most one add;
// a tick gives one delete per steered slot, the final one with last.
// A two-entry queue lets the front take events while the back sweeps.
// When rsp is stalled the output register holds, and the sweep waits when it
// has another command to load.
// Reset empties the table at once (valid bits only) and loads register
// defaults; no clearing pass is needed.
`timescale 1ns / 1ps
module wifi_client_steering_table
	import stt_pkg::*;
#(
	parameter int CLIENT_SLOTS = SLOTS_DEFAULT
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  req_t              req,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output rsp_t              rsp,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	cfg_t   cfg_q;
	qstat_t qstat;
	logic   push;
	logic   pop;
	work_t  push_data;
	work_t  head;
	logic   wr;
	logic [2:0] ridx;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite && pready;
	assign ridx   = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.strong_lim <= STRONG_RESET;
			cfg_q.weak_lim   <= WEAK_RESET;
			cfg_q.expiry     <= EXPIRY_RESET;
			cfg_q.pres_24    <= 1'b0;
			cfg_q.pres_5     <= 1'b0;
			cfg_q.rdy_24     <= 1'b0;
			cfg_q.rdy_5      <= 1'b0;
		end else if (wr) begin
			case (ridx)
				REG_STRONG:  cfg_q.strong_lim <= pwdata[7:0];
				REG_WEAK:    cfg_q.weak_lim   <= pwdata[7:0];
				REG_EXPIRY:  cfg_q.expiry     <= pwdata[15:0];
				REG_24_PRES: cfg_q.pres_24    <= pwdata[0];
				REG_5_PRES:  cfg_q.pres_5     <= pwdata[0];
				REG_24_RDY:  cfg_q.rdy_24     <= pwdata[0];
				REG_5_RDY:   cfg_q.rdy_5      <= pwdata[0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (ridx)
			REG_STRONG:  prdata = {24'd0, cfg_q.strong_lim};
			REG_WEAK:    prdata = {24'd0, cfg_q.weak_lim};
			REG_EXPIRY:  prdata = {16'd0, cfg_q.expiry};
			REG_24_PRES: prdata = {31'd0, cfg_q.pres_24};
			REG_5_PRES:  prdata = {31'd0, cfg_q.pres_5};
			REG_24_RDY:  prdata = {31'd0, cfg_q.rdy_24};
			REG_5_RDY:   prdata = {31'd0, cfg_q.rdy_5};
			default:     prdata = 32'd0;
		endcase
	end

	stt_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.qstat     (qstat),
		.push      (push),
		.push_data (push_data)
	);

	stt_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.qstat     (qstat)
	);

	stt_back #(
		.CLIENT_SLOTS (CLIENT_SLOTS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.head      (head),
		.qstat     (qstat),
		.pop       (pop),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && qstat.full))
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !qstat.empty)
		else $error("queue read while empty");

	a_add_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.command == CMD_ADD |-> rsp.last)
		else $error("add command without last");

endmodule

// ----- bench/wifi_client_steering_table_tb.sv -----
// testbench for the client steering table: random and directed events, commands
// checked against a behavioral table model; depends on stt_pkg and the top level
`timescale 1ns / 1ps
module wifi_client_steering_table_tb;
	import stt_pkg::*;

	localparam int SLOTS = 64;
	localparam int CYCLE_LIMIT = 900000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	wifi_client_steering_table #(.CLIENT_SLOTS(SLOTS)) u_top (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #2 clk = ~clk;

	// table model
	logic              tbl_valid [SLOTS];
	logic [47:0]       tbl_mac [SLOTS];
	logic              tbl_vht [SLOTS];
	logic [3:0]        tbl_streams [SLOTS];
	logic [1:0]        tbl_band [SLOTS];
	logic [1:0]        tbl_link [SLOTS];
	logic signed [7:0] tbl_rssi [SLOTS];
	logic [31:0]       tbl_seen [SLOTS];
	cfg_t model_cfg;

	req_t pending_events[$];
	rsp_t expected_cmds[$];
	int sender_idle_pct = 0;
	int stall_pct = 0;
	int mismatches = 0;
	int cmds_seen = 0;
	int events_sent = 0;
	longint cycles = 0;
	logic [31:0] clock_now = 0;
	logic [47:0] mac_pool [16];

	function automatic int match_slot(logic [47:0] mac);
		for (int i = 0; i < SLOTS; i++)
			if (tbl_valid[i] && tbl_mac[i] == mac) return i;
		return -1;
	endfunction

	function automatic void fill_client(int i, logic [47:0] mac);
		tbl_valid[i] = 1'b1; tbl_mac[i] = mac; tbl_vht[i] = 1'b0;
		tbl_streams[i] = '0; tbl_band[i] = BAND_NONE; tbl_link[i] = LINK_INIT;
		tbl_rssi[i] = '0; tbl_seen[i] = '0;
	endfunction

	function automatic int admit_client(logic [47:0] mac, logic [31:0] now);
		int pick;
		logic [31:0] oldest;
		pick = match_slot(mac);
		if (pick >= 0) return pick;
		for (int i = 0; i < SLOTS; i++)
			if (!tbl_valid[i]) begin
				fill_client(i, mac);
				return i;
			end
		oldest = now;
		pick = -1;
		for (int i = 0; i < SLOTS; i++)
			if (tbl_link[i] != LINK_ASSOC && tbl_seen[i] < oldest) begin
				oldest = tbl_seen[i];
				pick = i;
			end
		if (pick < 0)
			for (int i = 0; i < SLOTS; i++)
				if (pick < 0 || tbl_seen[i] < oldest) begin
					oldest = tbl_seen[i];
					pick = i;
				end
		fill_client(pick, mac);
		return pick;
	endfunction

	function automatic void push_cmd(logic c, logic [1:0] b, logic [47:0] m);
		rsp_t r;
		r.command = c; r.cmd_band = b; r.cmd_mac = m; r.last = 1'b0;
		expected_cmds.push_back(r);
	endfunction

	function automatic void apply_event(req_t e);
		logic signed [7:0] best;
		logic signed [7:0] rd [4];
		int i, n;
		rd = '{e.rssi_a, e.rssi_b, e.rssi_c, e.rssi_d};
		best = RSSI_NONE;
		n = 0;
		foreach (rd[r])
			if (rd[r] != RSSI_NONE && rd[r] > best) best = rd[r];
		case (e.mode)
			MODE_PROBE: begin
				i = match_slot(e.mac);
				if (i >= 0) begin
					tbl_rssi[i] = best; tbl_seen[i] = e.now_seconds;
					if (e.vht) tbl_vht[i] = 1'b1;
				end
			end
			MODE_DISASSOC: begin
				i = match_slot(e.mac);
				if (i >= 0) begin
					tbl_link[i] = LINK_DISASSOC; tbl_band[i] = BAND_NONE;
				end
			end
			MODE_ASSOC: begin
				i = admit_client(e.mac, e.now_seconds);
				tbl_seen[i] = e.now_seconds;
				if (e.vht) tbl_vht[i] = 1'b1;
				if (e.streams > tbl_streams[i]) tbl_streams[i] = e.streams;
				tbl_band[i] = e.band;
				tbl_link[i] = LINK_ASSOC;
				if ((e.band == BAND_5 && model_cfg.pres_5) ||
				    (e.band == BAND_24 && model_cfg.pres_24)) begin
					push_cmd(CMD_ADD, e.band, e.mac);
					n = 1;
				end
			end
			MODE_AUTH: begin
				i = admit_client(e.mac, e.now_seconds);
				tbl_rssi[i] = best; tbl_seen[i] = e.now_seconds;
			end
			MODE_TICK: begin
				for (int s = 0; s < SLOTS; s++)
					if (tbl_valid[s] && tbl_link[s] != LINK_ASSOC &&
					    e.now_seconds >= tbl_seen[s] &&
					    e.now_seconds - tbl_seen[s] > {16'd0, model_cfg.expiry})
						tbl_valid[s] = 1'b0;
				for (int s = 0; s < SLOTS; s++) begin
					if (!tbl_valid[s] || tbl_link[s] != LINK_ASSOC) continue;
					if (tbl_band[s] == BAND_24 && tbl_vht[s] &&
					    tbl_rssi[s] > model_cfg.strong_lim && model_cfg.rdy_24) begin
						push_cmd(CMD_DEL, BAND_24, tbl_mac[s]);
						n++;
						tbl_link[s] = LINK_INIT; tbl_band[s] = BAND_NONE;
					end
					if (tbl_band[s] == BAND_5 && tbl_rssi[s] < model_cfg.weak_lim &&
					    tbl_rssi[s] != 0 && model_cfg.rdy_5) begin
						push_cmd(CMD_DEL, BAND_5, tbl_mac[s]);
						n++;
						tbl_link[s] = LINK_INIT; tbl_band[s] = BAND_NONE;
					end
				end
			end
			default: ;
		endcase
		if (n > 0) expected_cmds[$].last = 1'b1;
	endfunction

	// driver: the head of pending_events is the item on req while req_valid is high
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (!req_valid || !req_stall) begin
			if (req_valid) pending_events.delete(0);
			if (pending_events.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
				req_valid <= 1'b1;
				req <= pending_events[0];
			end else begin
				req_valid <= 1'b0;
				req <= '0;
			end
		end
		rsp_stall <= ($urandom_range(99) < stall_pct);
	end

	// monitor: prediction happens on acceptance, so ordering follows the block
	always @(posedge clk) begin
		if (arst_n && req_valid && !req_stall) begin
			apply_event(req);
			events_sent <= events_sent + 1;
		end
		if (arst_n && rsp_valid && !rsp_stall) begin
			cmds_seen <= cmds_seen + 1;
			if (expected_cmds.size() == 0) begin
				mismatches <= mismatches + 1;
				if (mismatches < 10) $display("unexpected command %p", rsp);
			end else begin
				if (rsp !== expected_cmds[0]) begin
					mismatches <= mismatches + 1;
					if (mismatches < 10)
						$display("command mismatch: expected %p got %p",
							expected_cmds[0], rsp);
				end
				expected_cmds.pop_front();
			end
		end
	end

	always @(posedge clk)
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("TEST FAILED");
			$finish;
		end

	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= ADDR_W'(idx) << 2; pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		case (idx)
			REG_STRONG:  model_cfg.strong_lim = val[7:0];
			REG_WEAK:    model_cfg.weak_lim = val[7:0];
			REG_EXPIRY:  model_cfg.expiry = val[15:0];
			REG_24_PRES: model_cfg.pres_24 = val[0];
			REG_5_PRES:  model_cfg.pres_5 = val[0];
			REG_24_RDY:  model_cfg.rdy_24 = val[0];
			REG_5_RDY:   model_cfg.rdy_5 = val[0];
			default: ;
		endcase
	endtask

	task automatic drain();
		while (pending_events.size() > 0 || req_valid || expected_cmds.size() > 0)
			@(posedge clk);
		// events that give no command may still be sweeping
		repeat (5 * (2 * SLOTS + 2) + 20) @(posedge clk);
	endtask

	function automatic logic signed [7:0] pick_rssi();
		case ($urandom_range(5))
			0: return RSSI_NONE;
			1: return 8'sd127;
			2: return 8'sd0;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	function automatic req_t make_event(logic [2:0] m);
		req_t e;
		e.mode = m;
		e.mac = ($urandom_range(9) == 0) ? 48'({$urandom, $urandom}) :
			mac_pool[$urandom_range(15)];
		e.band = ($urandom_range(4) == 0) ? 2'($urandom_range(3)) : 2'($urandom_range(1, 2));
		e.rssi_a = pick_rssi(); e.rssi_b = pick_rssi();
		e.rssi_c = pick_rssi(); e.rssi_d = pick_rssi();
		e.vht = 1'($urandom_range(1));
		e.streams = 4'($urandom_range(15));
		clock_now = clock_now + (($urandom_range(3) == 0) ? $urandom_range(400) : 1);
		// occasional stale timestamp exercises the no-expiry case
		e.now_seconds = ($urandom_range(15) == 0) ? clock_now - 50 : clock_now;
		return e;
	endfunction

	task automatic random_phase(int count, int idle, int stall);
		logic [2:0] m;
		sender_idle_pct = idle;
		stall_pct = stall;
		for (int k = 0; k < count; k++) begin
			case ($urandom_range(15))
				0, 1, 2:    m = MODE_PROBE;
				3:          m = MODE_DISASSOC;
				4, 5, 6, 7: m = MODE_ASSOC;
				8, 9, 10:   m = MODE_AUTH;
				11, 12, 13: m = MODE_TICK;
				default:    m = 3'($urandom_range(7));
			endcase
			pending_events.push_back(make_event(m));
		end
		drain();
	endtask

	initial begin
		req_t e;
		model_cfg = '{strong_lim: STRONG_RESET, weak_lim: WEAK_RESET, expiry: EXPIRY_RESET,
			pres_24: 1'b0, pres_5: 1'b0, rdy_24: 1'b0, rdy_5: 1'b0};
		foreach (tbl_valid[i]) fill_client(i, '0);
		foreach (tbl_valid[i]) tbl_valid[i] = 1'b0;
		for (int i = 0; i < 16; i++) mac_pool[i] = 48'({$urandom, $urandom});
		mac_pool[0] = '0;
		mac_pool[1] = '1;
		clock_now = 32'd1000;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: defaults first, then every interface enabled
		e = make_event(MODE_ASSOC); e.mac = '1; e.band = BAND_5;
		pending_events.push_back(e);
		e.mode = MODE_PROBE; e.mac = 48'h123;
		pending_events.push_back(e);
		e.mode = MODE_DISASSOC;
		pending_events.push_back(e);
		drain();
		write_reg(REG_24_PRES, 1); write_reg(REG_5_PRES, 1);
		write_reg(REG_24_RDY, 1); write_reg(REG_5_RDY, 1);
		foreach (mac_pool[i]) begin
			e = make_event(MODE_ASSOC);
			e.mac = mac_pool[i]; e.band = (i % 2) ? BAND_24 : BAND_5;
			e.vht = 1'b1;
			pending_events.push_back(e);
			if (i < 4) begin
				e.mode = MODE_PROBE;
				e.rssi_a = (i % 2) ? 8'sd127 : -8'sd127;
				e.rssi_b = RSSI_NONE; e.rssi_c = RSSI_NONE; e.rssi_d = RSSI_NONE;
				pending_events.push_back(e);
			end
		end
		e = make_event(MODE_TICK);
		pending_events.push_back(e);
		e.mode = 3'd7;
		pending_events.push_back(e);
		drain();

		// fill past capacity to force eviction
		for (int k = 0; k < 80; k++) begin
			e = make_event(($urandom_range(2) == 0) ? MODE_ASSOC : MODE_AUTH);
			e.mac = {16'hbeef, 32'(k)};
			pending_events.push_back(e);
		end
		drain();

		random_phase(100, 0, 0);
		write_reg(REG_STRONG, 32'h80); write_reg(REG_WEAK, 32'h7f);
		write_reg(REG_EXPIRY, 0);
		random_phase(90, 82, 0);
		write_reg(REG_STRONG, 32'h7f); write_reg(REG_WEAK, 32'h80);
		write_reg(REG_EXPIRY, 32'hffff); write_reg(REG_5_RDY, 0);
		random_phase(90, 0, 82);
		write_reg(REG_STRONG, 32'hc0); write_reg(REG_WEAK, 32'hc0);
		write_reg(REG_EXPIRY, 100); write_reg(REG_5_RDY, 1);
		write_reg(REG_24_PRES, 0);
		random_phase(90, 25, 25);

		$display("covered %0d events and %0d commands over four register settings",
			events_sent, cmds_seen);
		$display("idle and stall patterns: none, sender only, receiver only, both");
		if (mismatches == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("TEST FAILED");
		end
		$finish;
	end
endmodule
